// File: rtl/jes3_pkg.sv
`default_nettype none
package jes3_pkg;

    localparam int DATA_WIDTH_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 32;

    localparam int ANG_W     = 64;
    localparam int Q_W       = 32;
    localparam int TAB_DEPTH = 48;
    localparam int TAB_AW    = 6;

    localparam int THR_W      = 31;
    localparam int MAXIT_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 2'd1;

    localparam logic [THR_W-1:0]   THRESHOLD_RST = 31'd66;
    localparam logic [MAXIT_W-1:0] MAX_ITER_RST  = 11'd16;

    localparam logic signed [ANG_W-1:0] PI_Q60       = 64'sh3243F6A8885A308D;
    localparam logic signed [ANG_W-1:0] PI4_Q60      = PI_Q60 >>> 2;
    localparam logic signed [ANG_W-1:0] GAIN_Q30     = 64'sd652032874;
    localparam logic signed [ANG_W-1:0] PRESCALE_LIM = 64'sd288230376151711744;
    localparam logic signed [ANG_W-1:0] ONE_Q30_W    = 64'sd1073741824;
    localparam logic signed [Q_W-1:0]   ONE_Q30      = 32'sd1073741824;

    typedef logic signed [ANG_W-1:0] t_atan_tab [TAB_DEPTH];

    // Bitwise long division, used only while building the angle table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q.60 by the truncated arctangent series.
    function automatic t_atan_tab build_atan();
        t_atan_tab   tab;
        logic [63:0] acc;
        logic [63:0] term;
        int          e;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            if (i == 0) begin
                tab[i] = PI4_Q60;
            end else begin
                acc = '0;
                for (int k = 0; k < 30; k++) begin
                    e = 60 - i * (2 * k + 1);
                    if (e >= 0) begin
                        term = udiv64(64'd1 << e, 64'(2 * k + 1));
                        acc  = (k % 2 == 1) ? acc - term : acc + term;
                    end
                end
                tab[i] = acc;
            end
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan();

    function automatic logic signed [Q_W-1:0] satq(input logic signed [ANG_W-1:0] v);
        if (v > ONE_Q30_W) begin
            return ONE_Q30;
        end else if (v < -ONE_Q30_W) begin
            return -ONE_Q30;
        end else begin
            return v[Q_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/jes3_qmul.sv
`default_nettype none
module jes3_qmul import jes3_pkg::*; #(
    parameter int A_W = 35
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [A_W-1:0] i_a,
    input  wire logic signed [Q_W-1:0] i_b,
    output logic                       o_done,
    output logic signed [A_W:0]        o_p
);
    localparam int CH_W  = 16;
    localparam int NCH   = (A_W + CH_W - 1) / CH_W;
    localparam int PAD_W = NCH * CH_W;
    localparam int PR_W  = PAD_W + Q_W;
    localparam int CNT_W = $clog2(NCH + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PAD_W-1:0]   r_ua;
    logic [Q_W-1:0]     r_ub;
    logic               r_neg;
    logic [PR_W-1:0]    r_acc;
    logic signed [A_W:0] r_p;

    logic [A_W-1:0]       ua_c;
    logic [Q_W-1:0]       ub_c;
    logic [CH_W+Q_W-1:0]  pp;
    logic [PR_W-1:0]      rnd;
    logic [A_W:0]         mag;

    assign ua_c = i_a[A_W-1] ? A_W'(-i_a) : A_W'(i_a);
    assign ub_c = i_b[Q_W-1] ? Q_W'(-i_b) : Q_W'(i_b);
    assign pp   = r_ua[PAD_W-1 -: CH_W] * r_ub;
    assign rnd  = r_acc + PR_W'(64'd1 << 29);
    assign mag  = (A_W+1)'(rnd >> 30);

    // Most significant chunk first: shift the partial sum up by one chunk each cycle.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NCH);
            r_ua   <= PAD_W'(ua_c);
            r_ub   <= ub_c;
            r_neg  <= i_a[A_W-1] != i_b[Q_W-1];
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_acc <= (r_acc << CH_W) + PR_W'(pp);
                r_ua  <= r_ua << CH_W;
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_p    <= r_neg ? -$signed(mag) : $signed(mag);
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule
`default_nettype wire

// File: rtl/jes3_cordic.sv
`default_nettype none
module jes3_cordic import jes3_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic                    i_vector,
    input  wire logic signed [ANG_W-1:0] i_x,
    input  wire logic signed [ANG_W-1:0] i_y,
    input  wire logic signed [ANG_W-1:0] i_z,
    output logic                         o_done,
    output logic signed [ANG_W-1:0]      o_angle,
    output logic signed [Q_W-1:0]        o_cos,
    output logic signed [Q_W-1:0]        o_sin
);
    localparam int IW = $clog2(STEPS);

    typedef enum logic [1:0] {C_IDLE, C_PRE, C_ITER} t_cstate;

    t_cstate                 r_state;
    logic                    r_vector;
    logic                    r_done;
    logic [IW-1:0]           r_step;
    logic signed [ANG_W-1:0] r_x;
    logic signed [ANG_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;

    logic signed [ANG_W-1:0] xs;
    logic signed [ANG_W-1:0] ys;
    logic signed [ANG_W-1:0] ang;
    logic                    up;
    logic                    grow;

    assign xs   = r_x >>> r_step;
    assign ys   = r_y >>> r_step;
    assign ang  = ATAN_TAB[TAB_AW'(r_step)];
    assign up   = r_vector ? r_y[ANG_W-1] : !r_z[ANG_W-1];
    assign grow = (r_x < PRESCALE_LIM) && (r_y < PRESCALE_LIM) && (r_y > -PRESCALE_LIM);

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_vector <= i_vector;
                    r_step   <= '0;
                    if (i_vector) begin
                        r_z <= '0;
                        // A zero numerator gives a zero angle at once.
                        if (i_y == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_x     <= i_x[ANG_W-1] ? -i_x : i_x;
                            r_y     <= i_x[ANG_W-1] ? -i_y : i_y;
                            r_state <= C_PRE;
                        end
                    end else begin
                        r_x     <= GAIN_Q30;
                        r_y     <= '0;
                        r_z     <= i_z;
                        r_state <= C_ITER;
                    end
                end
            end
            C_PRE: begin
                if (grow) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end else begin
                    r_state <= C_ITER;
                end
            end
            C_ITER: begin
                if (up) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - ang;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + ang;
                end
                if (r_step == IW'(STEPS - 1)) begin
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            default: r_state <= C_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;
    assign o_cos   = satq(r_x);
    assign o_sin   = satq(r_y);

endmodule
`default_nettype wire

// File: rtl/jacobi_eigen_3x3_symmetric_top.sv
// A run is P rotation passes (1 to max_iterations), then the three eigenpairs on o_strobe in order.
// Each pass runs the vectoring CORDIC only when the diagonals are not near-equal (a zero coupling
// finishes it at once, otherwise prescale doublings come first), then the rotation CORDIC, then
// 27 products on the single shared chunked multiplier.
// A new matrix is taken only while idle; busy drops as the third result is driven.
// Reset (synchronous, active low) idles the sequencer and restores threshold 66, max_iterations 16.
`default_nettype none
module jacobi_eigen_3x3_symmetric_top import jes3_pkg::*; #(
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [DATA_WIDTH-1:0] i_a00,
    input  wire logic signed [DATA_WIDTH-1:0] i_a01,
    input  wire logic signed [DATA_WIDTH-1:0] i_a02,
    input  wire logic signed [DATA_WIDTH-1:0] i_a11,
    input  wire logic signed [DATA_WIDTH-1:0] i_a12,
    input  wire logic signed [DATA_WIDTH-1:0] i_a22,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic [1:0]                        o_pair_index,
    output logic signed [DATA_WIDTH+1:0]      o_eigenvalue,
    output logic signed [Q_W-1:0]             o_vec_x,
    output logic signed [Q_W-1:0]             o_vec_y,
    output logic signed [Q_W-1:0]             o_vec_z,
    output logic                              o_last
);
    localparam int DW    = DATA_WIDTH + 2;
    localparam int GAP_W = DATA_WIDTH + 3;
    localparam int MA_W  = (GAP_W > Q_W + 1) ? GAP_W : Q_W + 1;
    localparam int MR_W  = MA_W + 1;
    localparam int ACC_W = MR_W + 2;
    localparam int CMP_W = (GAP_W > Q_W) ? GAP_W : Q_W;

    localparam logic signed [ACC_W-1:0] D_MAX = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] D_MIN = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

    localparam logic [4:0] UOP_ROW0 = 5'd15;
    localparam logic [4:0] UOP_LAST = 5'd26;

    typedef enum logic [3:0] {
        S_IDLE, S_PICK, S_THETA, S_VEC_WAIT, S_ROT_GO, S_ROT_WAIT, S_MUL_GO, S_MUL_WAIT, S_EMIT
    } t_state;
    typedef enum logic [1:0] {PAIR_01, PAIR_02, PAIR_12} t_pair;
    typedef enum logic [3:0] {A_CS, A_SN, A_II, A_JJ, A_IJ, A_KI, A_KJ, A_GAPN, A_SI, A_SJ} t_asel;
    typedef enum logic [2:0] {B_CS, B_SN, B_CC, B_SS, B_CSN, B_CMS} t_bsel;
    typedef enum logic [2:0] {ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD2, ACC_SUB2} t_accm;
    typedef enum logic [3:0] {
        DST_NONE, DST_CC, DST_SS, DST_CSN, DST_II, DST_JJ, DST_IJ, DST_MI, DST_MJ, DST_TMP, DST_SROW
    } t_dst;
    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        t_accm mode;
        t_dst  dst;
    } t_uop;

    function automatic t_uop uop_decode(input logic [4:0] idx, input logic [1:0] sub);
        t_uop u;
        u = '{asel: A_CS, bsel: B_CS, mode: ACC_LOAD, dst: DST_NONE};
        unique case (idx)
            5'd0:  u = '{A_CS,   B_CS,  ACC_LOAD, DST_CC};
            5'd1:  u = '{A_SN,   B_SN,  ACC_LOAD, DST_SS};
            5'd2:  u = '{A_CS,   B_SN,  ACC_LOAD, DST_CSN};
            5'd3:  u = '{A_II,   B_CC,  ACC_LOAD, DST_NONE};
            5'd4:  u = '{A_IJ,   B_CSN, ACC_ADD2, DST_NONE};
            5'd5:  u = '{A_JJ,   B_SS,  ACC_ADD,  DST_II};
            5'd6:  u = '{A_II,   B_SS,  ACC_LOAD, DST_NONE};
            5'd7:  u = '{A_IJ,   B_CSN, ACC_SUB2, DST_NONE};
            5'd8:  u = '{A_JJ,   B_CC,  ACC_ADD,  DST_JJ};
            5'd9:  u = '{A_GAPN, B_CSN, ACC_LOAD, DST_NONE};
            5'd10: u = '{A_IJ,   B_CMS, ACC_ADD,  DST_IJ};
            5'd11: u = '{A_KI,   B_CS,  ACC_LOAD, DST_NONE};
            5'd12: u = '{A_KJ,   B_SN,  ACC_ADD,  DST_MI};
            5'd13: u = '{A_KJ,   B_CS,  ACC_LOAD, DST_NONE};
            5'd14: u = '{A_KI,   B_SN,  ACC_SUB,  DST_MJ};
            default: begin
                // Eigenvector rows: four products per row of S.
                unique case (sub)
                    2'd0:    u = '{A_SI, B_CS, ACC_LOAD, DST_NONE};
                    2'd1:    u = '{A_SJ, B_SN, ACC_ADD,  DST_TMP};
                    2'd2:    u = '{A_SJ, B_CS, ACC_LOAD, DST_NONE};
                    default: u = '{A_SI, B_SN, ACC_SUB,  DST_SROW};
                endcase
            end
        endcase
        return u;
    endfunction

    function automatic logic signed [DW-1:0] satd(input logic signed [ACC_W-1:0] v);
        if (v > D_MAX) begin
            return D_MAX[DW-1:0];
        end else if (v < D_MIN) begin
            return D_MIN[DW-1:0];
        end else begin
            return v[DW-1:0];
        end
    endfunction

    function automatic logic [DW-1:0] dabs(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    t_state                  r_state;
    logic [THR_W-1:0]        r_thr;
    logic [MAXIT_W-1:0]      r_max_it;
    logic [MAXIT_W-1:0]      r_iter;
    t_pair                   r_pair;
    logic [4:0]              r_uop;
    logic [1:0]              r_k;
    logic signed [DW-1:0]    r_d00, r_d01, r_d02, r_d11, r_d12, r_d22;
    logic signed [DW-1:0]    r_aii, r_ajj, r_aij, r_aki, r_akj;
    logic signed [Q_W-1:0]   r_s [3][3];
    logic signed [ANG_W-1:0] r_theta;
    logic signed [Q_W-1:0]   r_cs, r_sn, r_cc, r_ss, r_csn, r_tmp;
    logic signed [ACC_W-1:0] r_acc;

    logic                    r_strobe;
    logic [1:0]              r_pair_index;
    logic signed [DW-1:0]    r_eig;
    logic signed [Q_W-1:0]   r_vx, r_vy, r_vz;
    logic                    r_last;

    logic [DW-1:0]           ab01, ab02, ab12, max_abs;
    t_pair                   pick_pair;
    logic                    stop;
    logic signed [GAP_W-1:0] gap, gap_n;
    logic [GAP_W-1:0]        gap_abs;
    logic                    gap_small;
    logic [4:0]              rel;
    logic [1:0]              row, sub, ci, cj;
    t_uop                    uop;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [Q_W-1:0]   mul_b;
    logic                    mul_done;
    logic signed [MR_W-1:0]  mul_p;
    logic signed [ACC_W-1:0] pe;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [DW-1:0]    res_d;
    logic signed [Q_W-1:0]   res_q;
    logic                    cor_start, cor_vector, cor_done;
    logic signed [ANG_W-1:0] cor_angle;
    logic signed [Q_W-1:0]   cor_cos, cor_sin;
    logic                    accept;

    assign accept      = start && !busy;
    assign busy        = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;

    // Largest off-diagonal, ties kept on the earlier pair.
    always_comb begin
        ab01      = dabs(r_d01);
        ab02      = dabs(r_d02);
        ab12      = dabs(r_d12);
        pick_pair = PAIR_01;
        max_abs   = ab01;
        if (ab02 > max_abs) begin
            pick_pair = PAIR_02;
            max_abs   = ab02;
        end
        if (ab12 > max_abs) begin
            pick_pair = PAIR_12;
            max_abs   = ab12;
        end
    end

    assign stop = (r_iter != '0)
                  && ((r_iter >= r_max_it) || !(CMP_W'(max_abs) > CMP_W'(r_thr)));

    assign gap       = GAP_W'(r_aii) - GAP_W'(r_ajj);
    assign gap_n     = GAP_W'(r_ajj) - GAP_W'(r_aii);
    assign gap_abs   = gap[GAP_W-1] ? GAP_W'(gap_n) : GAP_W'(gap);
    assign gap_small = CMP_W'(gap_abs) < CMP_W'(r_thr);

    assign rel = r_uop - UOP_ROW0;
    assign row = rel[3:2];
    assign sub = rel[1:0];
    assign uop = uop_decode(r_uop, sub);

    always_comb begin
        unique case (r_pair)
            PAIR_01: begin ci = 2'd0; cj = 2'd1; end
            PAIR_02: begin ci = 2'd0; cj = 2'd2; end
            default: begin ci = 2'd1; cj = 2'd2; end
        endcase
    end

    always_comb begin
        unique case (uop.asel)
            A_CS:    mul_a = MA_W'(r_cs);
            A_SN:    mul_a = MA_W'(r_sn);
            A_II:    mul_a = MA_W'(r_aii);
            A_JJ:    mul_a = MA_W'(r_ajj);
            A_IJ:    mul_a = MA_W'(r_aij);
            A_KI:    mul_a = MA_W'(r_aki);
            A_KJ:    mul_a = MA_W'(r_akj);
            A_GAPN:  mul_a = MA_W'(gap_n);
            A_SI:    mul_a = MA_W'(r_s[row][ci]);
            default: mul_a = MA_W'(r_s[row][cj]);
        endcase
        unique case (uop.bsel)
            B_CS:    mul_b = r_cs;
            B_SN:    mul_b = r_sn;
            B_CC:    mul_b = r_cc;
            B_SS:    mul_b = r_ss;
            B_CSN:   mul_b = r_csn;
            default: mul_b = r_cc - r_ss;
        endcase
    end

    assign pe = ACC_W'(mul_p);

    always_comb begin
        unique case (uop.mode)
            ACC_LOAD: n_acc = pe;
            ACC_ADD:  n_acc = r_acc + pe;
            ACC_SUB:  n_acc = r_acc - pe;
            ACC_ADD2: n_acc = r_acc + (pe <<< 1);
            default:  n_acc = r_acc - (pe <<< 1);
        endcase
    end

    assign res_d = satd(n_acc);
    assign res_q = satq(ANG_W'(n_acc));

    assign cor_vector = r_state == S_THETA;
    assign cor_start  = (r_state == S_THETA && !gap_small) || r_state == S_ROT_GO;

    jes3_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cor_start),
        .i_vector (cor_vector),
        .i_x      (ANG_W'(gap)),
        .i_y      (ANG_W'(r_aij) <<< 1),
        .i_z      (r_theta),
        .o_done   (cor_done),
        .o_angle  (cor_angle),
        .o_cos    (cor_cos),
        .o_sin    (cor_sin)
    );

    jes3_qmul #(
        .A_W (MA_W)
    ) u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL_GO),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_ff @(posedge i_clk) begin
        r_strobe <= 1'b0;
        if (i_cfg_valid && i_cfg_index == REG_THRESHOLD) begin
            r_thr <= i_cfg_data[THR_W-1:0];
        end
        if (i_cfg_valid && i_cfg_index == REG_MAX_ITER) begin
            r_max_it <= i_cfg_data[MAXIT_W-1:0];
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_d00  <= DW'(i_a00);
                    r_d01  <= DW'(i_a01);
                    r_d02  <= DW'(i_a02);
                    r_d11  <= DW'(i_a11);
                    r_d12  <= DW'(i_a12);
                    r_d22  <= DW'(i_a22);
                    for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 3; c++) begin
                            r_s[r][c] <= (r == c) ? ONE_Q30 : '0;
                        end
                    end
                    r_iter  <= '0;
                    r_state <= S_PICK;
                end
            end
            S_PICK: begin
                if (stop) begin
                    r_k     <= 2'd0;
                    r_state <= S_EMIT;
                end else begin
                    r_pair <= pick_pair;
                    unique case (pick_pair)
                        PAIR_01: begin
                            r_aii <= r_d00; r_ajj <= r_d11; r_aij <= r_d01;
                            r_aki <= r_d02; r_akj <= r_d12;
                        end
                        PAIR_02: begin
                            r_aii <= r_d00; r_ajj <= r_d22; r_aij <= r_d02;
                            r_aki <= r_d01; r_akj <= r_d12;
                        end
                        default: begin
                            r_aii <= r_d11; r_ajj <= r_d22; r_aij <= r_d12;
                            r_aki <= r_d01; r_akj <= r_d02;
                        end
                    endcase
                    r_state <= S_THETA;
                end
            end
            S_THETA: begin
                if (gap_small) begin
                    r_theta <= (!r_aij[DW-1] && r_aij != '0) ? PI4_Q60 : -PI4_Q60;
                    r_state <= S_ROT_GO;
                end else begin
                    r_state <= S_VEC_WAIT;
                end
            end
            S_VEC_WAIT: begin
                if (cor_done) begin
                    r_theta <= cor_angle >>> 1;
                    r_state <= S_ROT_GO;
                end
            end
            S_ROT_GO: r_state <= S_ROT_WAIT;
            S_ROT_WAIT: begin
                if (cor_done) begin
                    r_cs    <= cor_cos;
                    r_sn    <= cor_sin;
                    r_uop   <= '0;
                    r_state <= S_MUL_GO;
                end
            end
            S_MUL_GO: r_state <= S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (mul_done) begin
                    r_acc <= n_acc;
                    unique case (uop.dst)
                        DST_NONE: ;
                        DST_CC:   r_cc  <= res_q;
                        DST_SS:   r_ss  <= res_q;
                        DST_CSN:  r_csn <= res_q;
                        DST_TMP:  r_tmp <= res_q;
                        DST_II: begin
                            if (r_pair == PAIR_12) r_d11 <= res_d;
                            else                   r_d00 <= res_d;
                        end
                        DST_JJ: begin
                            if (r_pair == PAIR_01) r_d11 <= res_d;
                            else                   r_d22 <= res_d;
                        end
                        DST_IJ: begin
                            unique case (r_pair)
                                PAIR_01: r_d01 <= res_d;
                                PAIR_02: r_d02 <= res_d;
                                default: r_d12 <= res_d;
                            endcase
                        end
                        DST_MI: begin
                            if (r_pair == PAIR_01) r_d02 <= res_d;
                            else                   r_d01 <= res_d;
                        end
                        DST_MJ: begin
                            if (r_pair == PAIR_12) r_d02 <= res_d;
                            else                   r_d12 <= res_d;
                        end
                        default: begin
                            // Commit both columns of the row together from the old values.
                            r_s[row][ci] <= r_tmp;
                            r_s[row][cj] <= res_q;
                        end
                    endcase
                    if (r_uop == UOP_LAST) begin
                        r_iter  <= r_iter + 1'b1;
                        r_state <= S_PICK;
                    end else begin
                        r_uop   <= r_uop + 1'b1;
                        r_state <= S_MUL_GO;
                    end
                end
            end
            S_EMIT: begin
                r_strobe     <= 1'b1;
                r_pair_index <= r_k;
                r_vx         <= r_s[0][r_k];
                r_vy         <= r_s[1][r_k];
                r_vz         <= r_s[2][r_k];
                r_last       <= r_k == 2'd2;
                unique case (r_k)
                    2'd0:    r_eig <= r_d00;
                    2'd1:    r_eig <= r_d11;
                    default: r_eig <= r_d22;
                endcase
                if (r_k == 2'd2) begin
                    r_state <= S_IDLE;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: r_state <= S_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_thr    <= THRESHOLD_RST;
            r_max_it <= MAX_ITER_RST;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_pair_index = r_pair_index;
    assign o_eigenvalue = r_eig;
    assign o_vec_x      = r_vx;
    assign o_vec_y      = r_vy;
    assign o_vec_z      = r_vz;
    assign o_last       = r_last && r_strobe;

`ifndef SYNTH
    a_last_is_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_strobe && o_pair_index == 2'd2))
        else $error("last flag without third eigenpair");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_pairs_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && o_pair_index == $past(o_pair_index) + 2'd1))
        else $error("eigenpairs not emitted back to back in order");

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL_WAIT))
        else $error("multiplier finished outside of a wait state");
`endif

endmodule
`default_nettype wire
